### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the BMP stream decoder (used by the parser).
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

### rtl/core/bsd_pkg.sv
// Types and constants of the BMP stream decoder.
// No dependencies.
`timescale 1ns / 1ps
package bsd_pkg;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
    localparam int PAL_W = 24;

    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4d;
    localparam logic [7:0] INFO_SIZE = 8'd40;
    localparam logic [7:0] BPP_8 = 8'd8;
    localparam logic [7:0] BPP_24 = 8'd24;
    localparam logic [7:0] BPP_32 = 8'd32;
    localparam logic [31:0] HEADER_BYTES = 32'd54;
    localparam logic [31:0] HEADER_END = 32'd53;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_PALETTE, PH_SKIP, PH_PIXEL, PH_PAD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0, KIND_PIXEL = 2'd1, KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0, ERR_SIGNATURE = 3'd1, ERR_INFO_SIZE = 3'd2,
        ERR_DEPTH = 3'd3, ERR_COLORS = 3'd4, ERR_OFFSET = 3'd5, ERR_LARGE = 3'd6
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_file;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        gray;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        last;
    } out_word_t;

    // result waiting for its palette lookup
    typedef struct packed {
        out_word_t res;
        logic      use_pal;
        logic      black;
    } pend_t;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] addr;
        logic [PAL_W-1:0]  data;
    } pal_wr_t;
endpackage

### rtl/core/bsd_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module bsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/bsd_parser.sv
// Header parser, palette loader and pixel sequencer; first pipeline stage.
// Depends on bsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsd_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  bsd_pkg::in_word_t                s_data,
    input  logic                             advance,
    output logic                             p_valid,
    output bsd_pkg::pend_t                   p_data,
    output bsd_pkg::pal_wr_t                 pal_wr,
    output logic                             pal_re,
    output logic [bsd_pkg::PAL_AW-1:0]       pal_raddr
);
    bsd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next, start_reg, start_next;
    logic [15:0] sig_reg, sig_next;
    logic [7:0]  info_reg, info_next, bpp_reg, bpp_next;
    logic [15:0] w_reg, w_next, h_reg, h_next, cc_reg, cc_next;
    logic        big_reg, big_next, gray_reg, gray_next;
    logic [8:0]  fill_reg, fill_next;
    logic [15:0] col_reg, col_next, rowc_reg, rowc_next;
    logic [1:0]  bip_reg, bip_next, pad_reg, pad_next, padamt_reg, padamt_next;
    logic [7:0]  pb_reg, pb_next, pg_reg, pg_next, pr_reg, pr_next;
    logic        p_valid_reg;
    bsd_pkg::pend_t p_reg;

    logic        accept;
    logic        emit_hdr, emit_err, emit_pix, pix_last, pix_pal, pix_black;
    logic [2:0]  err_code;
    logic [15:0] pix_col, pix_row;
    bsd_pkg::pend_t p_next;

    assign accept = s_valid && advance;

    // datapath and phase
    always_comb begin
        logic [7:0]  b;
        logic [31:0] p;
        logic [31:0] end_pos;
        logic [15:0] ccr;
        logic        do_finish;
        b = s_data.data_byte;
        p = '0;
        end_pos = '0;
        ccr = '0;
        do_finish = 1'b0;
        phase_next = phase_reg;
        pos_next = pos_reg;   start_next = start_reg; sig_next = sig_reg;
        info_next = info_reg; bpp_next = bpp_reg;     w_next = w_reg;
        h_next = h_reg;       cc_next = cc_reg;       big_next = big_reg;
        gray_next = gray_reg; fill_next = fill_reg;   col_next = col_reg;
        rowc_next = rowc_reg; bip_next = bip_reg;     pad_next = pad_reg;
        padamt_next = padamt_reg;
        pb_next = pb_reg;     pg_next = pg_reg;       pr_next = pr_reg;
        emit_hdr = 1'b0; emit_err = 1'b0; emit_pix = 1'b0;
        pix_last = 1'b0; pix_pal = 1'b0; pix_black = 1'b0;
        err_code = bsd_pkg::ERR_NONE;
        pix_col = '0; pix_row = '0;
        pal_wr = '0;
        if (accept) begin
            if (s_data.new_file) begin
                phase_next = bsd_pkg::PH_HEADER;
                pos_next = '0; start_next = '0; sig_next = '0; info_next = '0;
                bpp_next = '0; w_next = '0; h_next = '0; cc_next = '0;
                big_next = 1'b0; gray_next = 1'b1; fill_next = '0;
                col_next = '0; rowc_next = '0; bip_next = '0; pad_next = '0;
                padamt_next = '0; pb_next = '0; pg_next = '0; pr_next = '0;
            end
            case (phase_next)
                bsd_pkg::PH_HEADER: begin
                    p = pos_next;
                    case (p)
                        32'd0:  sig_next[7:0] = b;
                        32'd1:  sig_next[15:8] = b;
                        32'd10: start_next[7:0] = b;
                        32'd11: start_next[15:8] = b;
                        32'd12: start_next[23:16] = b;
                        32'd13: start_next[31:24] = b;
                        32'd14: info_next = b;
                        32'd18: w_next[7:0] = b;
                        32'd19: w_next[15:8] = b;
                        32'd20, 32'd21, 32'd24, 32'd25: big_next = big_next | (b != 8'd0);
                        32'd22: h_next[7:0] = b;
                        32'd23: h_next[15:8] = b;
                        32'd28: bpp_next = b;
                        32'd46: cc_next[7:0] = b;
                        32'd47: cc_next[15:8] = b;
                        default: ;
                    endcase
                    pos_next = p + 32'd1;
                    if (p == bsd_pkg::HEADER_END) begin
                        ccr = (cc_next == 16'd0) ? 16'(bsd_pkg::PALETTE_ENTRIES) : cc_next;
                        end_pos = bsd_pkg::HEADER_BYTES;
                        if (bpp_next == bsd_pkg::BPP_8) begin
                            end_pos = bsd_pkg::HEADER_BYTES + {14'd0, ccr, 2'b00};
                        end
                        if (sig_next != {bsd_pkg::SIG_M, bsd_pkg::SIG_B}) begin
                            err_code = bsd_pkg::ERR_SIGNATURE;
                        end else if (info_next != bsd_pkg::INFO_SIZE) begin
                            err_code = bsd_pkg::ERR_INFO_SIZE;
                        end else if (bpp_next == bsd_pkg::BPP_8 &&
                                     ccr > 16'(bsd_pkg::PALETTE_ENTRIES)) begin
                            err_code = bsd_pkg::ERR_COLORS;
                        end else if (bpp_next != bsd_pkg::BPP_8 &&
                                     bpp_next != bsd_pkg::BPP_24 &&
                                     bpp_next != bsd_pkg::BPP_32) begin
                            err_code = bsd_pkg::ERR_DEPTH;
                        end else if (start_next < end_pos) begin
                            err_code = bsd_pkg::ERR_OFFSET;
                        end else if (big_next) begin
                            err_code = bsd_pkg::ERR_LARGE;
                        end
                        if (err_code != bsd_pkg::ERR_NONE) begin
                            emit_err = 1'b1;
                            phase_next = bsd_pkg::PH_IDLE;
                        end else if (bpp_next == bsd_pkg::BPP_8) begin
                            phase_next = bsd_pkg::PH_PALETTE;
                            cc_next = ccr;
                            fill_next = '0;
                            bip_next = '0;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                end
                bsd_pkg::PH_PALETTE: begin
                    pos_next = pos_next + 32'd1;
                    case (bip_next)
                        2'd0: pb_next = b;
                        2'd1: pg_next = b;
                        2'd2: begin
                            pal_wr.we = 1'b1;
                            pal_wr.addr = fill_next[bsd_pkg::PAL_AW-1:0];
                            pal_wr.data = {b, pg_next, pb_next};
                            if (pb_next != pg_next || pb_next != b) begin
                                gray_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                    if (bip_next != 2'd3) begin
                        bip_next = bip_next + 2'd1;
                    end else begin
                        bip_next = '0;
                        fill_next = fill_next + 9'd1;
                        if ({7'd0, fill_next} >= cc_next) begin
                            do_finish = 1'b1;
                        end
                    end
                end
                bsd_pkg::PH_SKIP: begin
                    pos_next = pos_next + 32'd1;
                    if (pos_next == start_next) begin
                        phase_next = bsd_pkg::PH_PIXEL;
                    end
                end
                bsd_pkg::PH_PIXEL: begin
                    if (bpp_next == bsd_pkg::BPP_8) begin
                        emit_pix = 1'b1;
                        pix_pal = 1'b1;
                        pix_black = ({8'd0, b} >= cc_next);
                    end else begin
                        case (bip_next)
                            2'd0: pb_next = b;
                            2'd1: pg_next = b;
                            2'd2: pr_next = b;
                            default: ;
                        endcase
                        if ((bpp_next == bsd_pkg::BPP_24 && bip_next < 2'd2) ||
                            (bpp_next != bsd_pkg::BPP_24 && bip_next < 2'd3)) begin
                            bip_next = bip_next + 2'd1;
                        end else begin
                            emit_pix = 1'b1;
                        end
                    end
                    if (emit_pix) begin
                        bip_next = '0;
                        pix_col = col_next;
                        pix_row = h_next - 16'd1 - rowc_next;
                        pix_last = ({1'b0, col_next} + 17'd1 == {1'b0, w_next}) &&
                                   ({1'b0, rowc_next} + 17'd1 == {1'b0, h_next});
                        col_next = col_next + 16'd1;
                        if (pix_last) begin
                            phase_next = bsd_pkg::PH_IDLE;
                        end else if (col_next >= w_next) begin
                            col_next = '0;
                            rowc_next = rowc_next + 16'd1;
                            if (padamt_next != 2'd0) begin
                                pad_next = padamt_next;
                                phase_next = bsd_pkg::PH_PAD;
                            end
                        end
                    end
                end
                bsd_pkg::PH_PAD: begin
                    pad_next = pad_next - 2'd1;
                    if (pad_next == 2'd0) begin
                        phase_next = bsd_pkg::PH_PIXEL;
                    end
                end
                default: ;
            endcase
            if (do_finish) begin
                emit_hdr = 1'b1;
                bip_next = '0;
                // row padding: bytes per row mod 4 from width mod 4
                case (bpp_next)
                    bsd_pkg::BPP_8:  padamt_next = 2'd0 - w_next[1:0];
                    bsd_pkg::BPP_24: padamt_next = 2'd0 - 2'(w_next[1:0] * 2'd3);
                    default:         padamt_next = 2'd0;
                endcase
                if (w_next == 16'd0 || h_next == 16'd0) begin
                    phase_next = bsd_pkg::PH_IDLE;
                end else if (pos_next == start_next) begin
                    phase_next = bsd_pkg::PH_PIXEL;
                end else begin
                    phase_next = bsd_pkg::PH_SKIP;
                end
            end
        end
    end

    // result formation
    always_comb begin
        p_next = '0;
        if (emit_err) begin
            p_next.res.kind = bsd_pkg::KIND_ERROR;
            p_next.res.error_code = err_code;
        end else if (emit_hdr) begin
            p_next.res.kind = bsd_pkg::KIND_HEADER;
            p_next.res.image_width = w_next;
            p_next.res.image_height = h_next;
            p_next.res.gray = (bpp_next == bsd_pkg::BPP_8) && gray_next;
        end else begin
            p_next.res.kind = bsd_pkg::KIND_PIXEL;
            p_next.res.gray = (bpp_next == bsd_pkg::BPP_8) && gray_next;
            p_next.res.column = pix_col;
            p_next.res.row = pix_row;
            p_next.res.blue = pb_next;
            p_next.res.green = pg_next;
            p_next.res.red = pr_next;
            p_next.res.last = pix_last;
            p_next.use_pal = pix_pal;
            p_next.black = pix_black;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bsd_pkg::PH_IDLE;
            pos_reg <= '0; start_reg <= '0; sig_reg <= '0; info_reg <= '0;
            bpp_reg <= '0; w_reg <= '0; h_reg <= '0; cc_reg <= '0;
            big_reg <= 1'b0; gray_reg <= 1'b1; fill_reg <= '0;
            col_reg <= '0; rowc_reg <= '0; bip_reg <= '0; pad_reg <= '0;
            padamt_reg <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg <= pos_next; start_reg <= start_next; sig_reg <= sig_next;
            info_reg <= info_next; bpp_reg <= bpp_next; w_reg <= w_next;
            h_reg <= h_next; cc_reg <= cc_next; big_reg <= big_next;
            gray_reg <= gray_next; fill_reg <= fill_next; col_reg <= col_next;
            rowc_reg <= rowc_next; bip_reg <= bip_next; pad_reg <= pad_next;
            padamt_reg <= padamt_next;
            if (advance) begin
                p_valid_reg <= emit_err || emit_hdr || emit_pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pb_reg <= pb_next;
        pg_reg <= pg_next;
        pr_reg <= pr_next;
        if (advance) begin
            p_reg <= p_next;
        end
    end

    assign p_valid = p_valid_reg;
    assign p_data = p_reg;
    assign pal_re = accept;
    assign pal_raddr = s_data.data_byte[bsd_pkg::PAL_AW-1:0];

    `ASSERT_RST(a_err_has_code, aclk, aresetn, p_valid_reg && p_reg.res.kind == bsd_pkg::KIND_ERROR |-> p_reg.res.error_code != bsd_pkg::ERR_NONE)
    `ASSERT_RST(a_restart_header, aclk, aresetn, accept && s_data.new_file |=> phase_reg == bsd_pkg::PH_HEADER)
    `ASSERT_RST(a_pad_nonzero, aclk, aresetn, phase_reg == bsd_pkg::PH_PAD |-> pad_reg != 2'd0)
endmodule

### rtl/core/bsd_output.sv
// Second stage: palette lookup merge and result register.
// Depends on bsd_pkg.
`timescale 1ns / 1ps
module bsd_output (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          p_valid,
    input  bsd_pkg::pend_t                p_data,
    input  logic [bsd_pkg::PAL_W-1:0]     pal_rdata,
    output logic                          advance,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bsd_pkg::out_word_t            m_data
);
    logic               m_valid_reg;
    bsd_pkg::out_word_t m_reg, m_next;

    assign advance = !m_valid_reg || m_ready;

    always_comb begin
        m_next = p_data.res;
        if (p_data.use_pal) begin
            if (p_data.black) begin
                m_next.blue = '0;
                m_next.green = '0;
                m_next.red = '0;
            end else begin
                m_next.blue = pal_rdata[7:0];
                m_next.green = p_data.res.gray ? 8'd0 : pal_rdata[15:8];
                m_next.red = p_data.res.gray ? 8'd0 : pal_rdata[23:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_reg <= m_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_reg;
endmodule

### rtl/core/bmp_stream_decoder.sv
// Top level of the BMP stream decoder: parser, palette RAM, output stage.
// Depends on bsd_pkg, bsd_ram, bsd_parser and bsd_output.
`timescale 1ns / 1ps
// Streaming decoder for uncompressed 8, 24 and 32 bpp BMP files. One file
// byte is taken per word on the s_ channel, at one word per clock while the
// m_ channel keeps up; a byte with new_file set restarts parsing. Each byte
// gives at most one result word, registered first in the parser, beside the
// registered palette RAM read (256 x 24 bits) that the 8 bpp pixel lookup
// needs, and then in the output stage. Results are a header word after the
// header (and palette), a pixel word per pixel with column and top-down row,
// or an error word. The whole pipeline stalls while a result waits at the
// output, so s_ready follows m_ready and the output register's state.
module bmp_stream_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bsd_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bsd_pkg::out_word_t  m_data
);
    logic                          advance;
    logic                          p_valid;
    bsd_pkg::pend_t                p_data;
    bsd_pkg::pal_wr_t              pal_wr;
    logic                          pal_re;
    logic [bsd_pkg::PAL_AW-1:0]    pal_raddr;
    logic [bsd_pkg::PAL_W-1:0]     pal_rdata;

    // whole pipeline moves together
    assign s_ready = advance;

    bsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .advance   (advance),
        .p_valid   (p_valid),
        .p_data    (p_data),
        .pal_wr    (pal_wr),
        .pal_re    (pal_re),
        .pal_raddr (pal_raddr)
    );

    // palette store; entries below the colour count are always loaded first
    bsd_ram #(
        .WIDTH (bsd_pkg::PAL_W),
        .DEPTH (bsd_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_wr.we),
        .waddr (pal_wr.addr),
        .wdata (pal_wr.data),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    bsd_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .p_valid   (p_valid),
        .p_data    (p_data),
        .pal_rdata (pal_rdata),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );
endmodule

### dv/bmp_stream_decoder_tb.sv
// Self-checking testbench for bmp_stream_decoder: BMP byte streams in, checked result words out.
// Depends on bsd_pkg and the decoder RTL. The result predictor lives in this file.
`timescale 1ns / 1ps
module bmp_stream_decoder_tb;
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bsd_pkg::in_word_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bsd_pkg::out_word_t  m_data;

    bmp_stream_decoder u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    bsd_pkg::in_word_t  byte_q[$];      // file bytes still to be sent
    bsd_pkg::out_word_t decoded_q[$];   // predicted result words, oldest first
    int                 fails = 0;
    bit                 in_reset = 1'b1;

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the decoder's file state
    // ---------------------------------------------------------------
    bsd_pkg::phase_t ph = bsd_pkg::PH_IDLE;
    logic [31:0] bpos, pstart, wid, hgt, ccount, fill, col_n, row_n;
    logic [15:0] sig;
    logic [7:0]  info, bpp, pb, pg, pr;
    logic [23:0] pal [bsd_pkg::PALETTE_ENTRIES];
    bit          gmode;
    int          bip, padl;

    task automatic clear_file();
        bpos = 0; pstart = 0; sig = 0; info = 0; wid = 0; hgt = 0; bpp = 0;
        ccount = 0; fill = 0; gmode = 1'b1; col_n = 0; row_n = 0; bip = 0;
        pb = 0; pg = 0; pr = 0; padl = 0;
    endtask

    // header done (and palette loaded): header word, then pick next phase
    task automatic header_word(output bsd_pkg::out_word_t r);
        r = '0;
        r.kind = bsd_pkg::KIND_HEADER;
        r.image_width = wid[15:0];
        r.image_height = hgt[15:0];
        r.gray = (bpp == bsd_pkg::BPP_8) && gmode;
        bip = 0;
        if (wid == 0 || hgt == 0) ph = bsd_pkg::PH_IDLE;
        else if (bpos == pstart) ph = bsd_pkg::PH_PIXEL;
        else ph = bsd_pkg::PH_SKIP;
    endtask

    // checks in the parser's order; a zero colour count means a full palette
    function automatic bsd_pkg::err_t header_fault();
        logic [31:0] hdr_end;
        hdr_end = bsd_pkg::HEADER_BYTES;
        if (sig[7:0] != bsd_pkg::SIG_B || sig[15:8] != bsd_pkg::SIG_M)
            return bsd_pkg::ERR_SIGNATURE;
        if (info != bsd_pkg::INFO_SIZE) return bsd_pkg::ERR_INFO_SIZE;
        if (bpp == bsd_pkg::BPP_8) begin
            if (ccount == 0) ccount = bsd_pkg::PALETTE_ENTRIES;
            if (ccount > bsd_pkg::PALETTE_ENTRIES) return bsd_pkg::ERR_COLORS;
            hdr_end += 4 * ccount;
        end else if (bpp != bsd_pkg::BPP_24 && bpp != bsd_pkg::BPP_32) begin
            return bsd_pkg::ERR_DEPTH;
        end
        if (pstart < hdr_end) return bsd_pkg::ERR_OFFSET;
        if (wid[31:16] != 0 || hgt[31:16] != 0) return bsd_pkg::ERR_LARGE;
        return bsd_pkg::ERR_NONE;
    endfunction

    task automatic decode_byte(bsd_pkg::in_word_t w);
        logic [7:0]         b;
        logic [31:0]        p, nb, pad;
        logic [23:0]        e;
        bsd_pkg::out_word_t r;
        bit                 has, lst;
        bsd_pkg::err_t      code;
        b = w.data_byte;
        has = 1'b0;
        r = '0;
        if (w.new_file) begin
            clear_file();
            ph = bsd_pkg::PH_HEADER;
        end
        case (ph)
            bsd_pkg::PH_HEADER: begin
                p = bpos;
                if (p == 0) sig[7:0] = b;
                else if (p == 1) sig[15:8] = b;
                else if (p >= 10 && p <= 13) pstart |= 32'(b) << (8 * (p - 10));
                else if (p == 14) info = b;
                else if (p >= 18 && p <= 21) wid |= 32'(b) << (8 * (p - 18));
                else if (p >= 22 && p <= 25) hgt |= 32'(b) << (8 * (p - 22));
                else if (p == 28) bpp = b;
                else if (p == 46 || p == 47) ccount |= 32'(b) << (8 * (p - 46));
                bpos = p + 1;
                if (p == bsd_pkg::HEADER_END) begin
                    code = header_fault();
                    has = 1'b1;
                    if (code != bsd_pkg::ERR_NONE) begin
                        r.kind = bsd_pkg::KIND_ERROR;
                        r.error_code = code;
                        ph = bsd_pkg::PH_IDLE;
                    end else if (bpp == bsd_pkg::BPP_8) begin
                        has = 1'b0;
                        ph = bsd_pkg::PH_PALETTE;
                        fill = 0;
                        bip = 0;
                    end else begin
                        header_word(r);
                    end
                end
            end
            bsd_pkg::PH_PALETTE: begin
                bpos++;
                if (bip == 0) pb = b;
                else if (bip == 1) pg = b;
                else if (bip == 2) begin
                    if (fill < bsd_pkg::PALETTE_ENTRIES) pal[fill] = {b, pg, pb};
                    if (pb != pg || pb != b) gmode = 1'b0;
                end
                if (bip < 3) bip++;
                else begin
                    bip = 0;
                    fill++;
                    if (fill >= ccount) begin
                        header_word(r);
                        has = 1'b1;
                    end
                end
            end
            bsd_pkg::PH_SKIP: begin
                bpos++;
                if (bpos == pstart) ph = bsd_pkg::PH_PIXEL;
            end
            bsd_pkg::PH_PIXEL: begin
                nb = bpp / 8;
                has = 1'b1;
                r.kind = bsd_pkg::KIND_PIXEL;
                if (bpp == bsd_pkg::BPP_8) begin
                    e = (b < ccount) ? pal[b] : 24'd0;   // unused index is black
                    r.blue = e[7:0];
                    if (gmode) r.gray = 1'b1;
                    else begin
                        r.green = e[15:8];
                        r.red = e[23:16];
                    end
                end else begin
                    if (bip == 0) pb = b;
                    else if (bip == 1) pg = b;
                    else if (bip == 2) pr = b;
                    if (bip + 1 < nb) begin
                        bip++;
                        has = 1'b0;
                    end
                    r.blue = pb; r.green = pg; r.red = pr;
                end
                if (has) begin
                    bip = 0;
                    lst = (col_n + 1 == wid) && (row_n + 1 == hgt);
                    r.column = col_n[15:0];
                    r.row = 16'(hgt - 1 - row_n);
                    r.last = lst;
                    col_n++;
                    if (lst) ph = bsd_pkg::PH_IDLE;
                    else if (col_n >= wid) begin
                        col_n = 0;
                        row_n++;
                        pad = (4 - (((wid & 3) * nb) & 3)) & 3;
                        if (pad != 0) begin
                            padl = pad;
                            ph = bsd_pkg::PH_PAD;
                        end
                    end
                end
            end
            bsd_pkg::PH_PAD: begin
                padl = (padl - 1) & 3;
                if (padl == 0) ph = bsd_pkg::PH_PIXEL;
            end
            default: ;
        endcase
        if (has) decoded_q.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Stimulus: whole BMP files, some faulty, some cut short
    // ---------------------------------------------------------------
    task automatic push_byte(logic [7:0] b, bit nf);
        bsd_pkg::in_word_t w;
        w.data_byte = b;
        w.new_file = nf;
        byte_q.push_back(w);
    endtask

    // fault uses err_t codes; cut >= 0 keeps only the first cut+1 bytes of the file
    task automatic add_file(logic [7:0] depth, logic [31:0] w, logic [31:0] h,
                            int ncol, int gap, bit grey, bsd_pkg::err_t fault, int cut);
        logic [7:0]  fb[$];
        logic [31:0] off, pe, hdr_end, cnt, nb, pad;
        logic [7:0]  g;
        for (int i = 0; i < 54; i++) fb.push_back($urandom_range(0, 255));
        pe = (ncol == 0) ? bsd_pkg::PALETTE_ENTRIES : ncol;
        hdr_end = bsd_pkg::HEADER_BYTES + ((depth == bsd_pkg::BPP_8) ? 4 * pe : 0);
        off = hdr_end + gap;
        cnt = ncol;
        fb[0] = bsd_pkg::SIG_B; fb[1] = bsd_pkg::SIG_M;
        fb[14] = bsd_pkg::INFO_SIZE; fb[28] = depth;
        case (fault)
            bsd_pkg::ERR_SIGNATURE: begin
                if ($urandom_range(0, 1)) fb[0] = bsd_pkg::SIG_B ^ 8'($urandom_range(1, 255));
                else fb[1] = bsd_pkg::SIG_M ^ 8'($urandom_range(1, 255));
            end
            bsd_pkg::ERR_INFO_SIZE: fb[14] = bsd_pkg::INFO_SIZE ^ 8'($urandom_range(1, 255));
            bsd_pkg::ERR_DEPTH: begin
                do fb[28] = $urandom_range(0, 255);
                while (fb[28] == bsd_pkg::BPP_8 || fb[28] == bsd_pkg::BPP_24 ||
                       fb[28] == bsd_pkg::BPP_32);
            end
            bsd_pkg::ERR_COLORS: cnt = $urandom_range(bsd_pkg::PALETTE_ENTRIES + 1, 65535);
            bsd_pkg::ERR_OFFSET: off = hdr_end - 1 - $urandom_range(0, 20);
            bsd_pkg::ERR_LARGE: begin
                if ($urandom_range(0, 1)) w |= 32'd1 << $urandom_range(16, 31);
                else h = -$urandom_range(1, 1000);   // top-down height
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) begin
            fb[10 + i] = off[8*i +: 8];
            fb[18 + i] = w[8*i +: 8];
            fb[22 + i] = h[8*i +: 8];
        end
        fb[46] = cnt[7:0];
        fb[47] = cnt[15:8];
        if (fault == bsd_pkg::ERR_NONE) begin
            if (depth == bsd_pkg::BPP_8) begin
                for (int i = 0; i < pe; i++) begin
                    g = $urandom_range(0, 255);
                    if (grey) repeat (3) fb.push_back(g);
                    else repeat (3) fb.push_back($urandom_range(0, 255));
                    fb.push_back($urandom_range(0, 255));
                end
            end
            repeat (gap) fb.push_back($urandom_range(0, 255));
            nb = depth / 8;
            pad = (4 - (((w & 3) * nb) & 3)) & 3;
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++) begin
                    if (depth == bsd_pkg::BPP_8)
                        fb.push_back(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, pe - 1));
                    else repeat (nb) fb.push_back($urandom_range(0, 255));
                end
                repeat (pad) fb.push_back($urandom_range(0, 255));
            end
        end
        if (cut >= 0 && cut < fb.size()) fb = fb[0:cut];
        foreach (fb[i]) push_byte(fb[i], i == 0);
    endtask

    task automatic add_random_file();
        logic [7:0]    depth;
        int            sel, cut;
        bsd_pkg::err_t fault;
        sel = $urandom_range(0, 2);
        depth = (sel == 0) ? bsd_pkg::BPP_8 : (sel == 1) ? bsd_pkg::BPP_24 : bsd_pkg::BPP_32;
        fault = bsd_pkg::ERR_NONE;
        if ($urandom_range(0, 5) == 0) fault = bsd_pkg::err_t'($urandom_range(1, 6));
        if (fault == bsd_pkg::ERR_COLORS) depth = bsd_pkg::BPP_8;
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 90) : -1;
        add_file(depth, $urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 6),
                 ($urandom_range(0, 1)) ? 0 : $urandom_range(1, 5),
                 $urandom_range(0, 2) == 0, fault, cut);
        // noise while idle, without new_file
        repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 255), 1'b0);
    endtask

    // ---------------------------------------------------------------
    // Driver: one byte word per handshake, random gaps, one drain pause
    // ---------------------------------------------------------------
    int  send_gap = 0;
    int  sent = 0;
    bit  drain_hold = 1'b0;
    bit  burst = 1'b0;

    always @(posedge aclk) begin
        bit take;
        take = s_valid && s_ready;
        if (in_reset) begin
            s_valid <= 1'b0;
        end else begin
            if (take) begin
                decode_byte(s_data);
                sent++;
                if (sent == 200) drain_hold = 1'b1;
                if ($urandom_range(0, 63) == 0) burst = !burst;
                if (!burst) begin
                    case ($urandom_range(0, 9))
                        0, 1:    send_gap = $urandom_range(1, 3);
                        2:       send_gap = $urandom_range(10, 40);
                        default: send_gap = 0;
                    endcase
                end
            end
            if (s_valid && !take) begin
                // hold the word until the decoder takes it
            end else if (drain_hold && decoded_q.size() != 0) begin
                s_valid <= 1'b0;
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                drain_hold = 1'b0;
                s_valid <= 1'b1;
                s_data <= byte_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare every result word with the oldest prediction
    // ---------------------------------------------------------------
    int got = 0;
    int rx_gap = 0;

    task automatic cmp(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        bsd_pkg::out_word_t e;
        if (in_reset) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got++;
                if (decoded_q.size() == 0) begin
                    $error("result word with no prediction waiting");
                    fails++;
                end else begin
                    e = decoded_q.pop_front();
                    cmp("kind", e.kind, m_data.kind);
                    cmp("error_code", e.error_code, m_data.error_code);
                    cmp("image_width", e.image_width, m_data.image_width);
                    cmp("image_height", e.image_height, m_data.image_height);
                    cmp("gray", e.gray, m_data.gray);
                    cmp("column", e.column, m_data.column);
                    cmp("row", e.row, m_data.row);
                    cmp("blue", e.blue, m_data.blue);
                    cmp("green", e.green, m_data.green);
                    cmp("red", e.red, m_data.red);
                    cmp("last", e.last, m_data.last);
                end
                // long back-pressure once, so the pipeline fills and s_ready drops
                if (got == 8) rx_gap = 300;
                else if (!burst) begin
                    case ($urandom_range(0, 9))
                        0, 1:    rx_gap = $urandom_range(1, 3);
                        2:       rx_gap = $urandom_range(10, 40);
                        default: rx_gap = 0;
                    endcase
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any handshake on either side
    int quiet = 0;
    always @(posedge aclk) begin
        if (in_reset || (s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else if (quiet == 20000) begin
            $display("FAIL bmp_stream_decoder");
            $finish;
        end else quiet <= quiet + 1;
    end

    initial begin
        // directed files: depths, gray and colour palettes, unused index,
        // offset skip, empty image, header faults
        add_file(bsd_pkg::BPP_24, 3, 2, 1, 0, 0, bsd_pkg::ERR_NONE, -1);
        add_file(bsd_pkg::BPP_8, 3, 1, 2, 0, 1, bsd_pkg::ERR_NONE, -1);
        add_file(bsd_pkg::BPP_8, 2, 1, 3, 1, 0, bsd_pkg::ERR_NONE, -1);
        add_file(bsd_pkg::BPP_24, 0, 3, 1, 1, 0, bsd_pkg::ERR_NONE, -1);
        add_file(bsd_pkg::BPP_24, 1, 1, 1, 0, 0, bsd_pkg::ERR_SIGNATURE, -1);
        add_file(bsd_pkg::BPP_8, 1, 1, 2, 0, 0, bsd_pkg::ERR_COLORS, -1);
        add_file(bsd_pkg::BPP_32, 1, 1, 1, 0, 0, bsd_pkg::ERR_LARGE, -1);
        repeat (5) push_byte($urandom_range(0, 255), 1'b0);
        while (byte_q.size() < 450) add_random_file();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        in_reset <= 1'b0;
        do @(posedge aclk);
        while (byte_q.size() != 0 || s_valid || decoded_q.size() != 0);
        repeat (20) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            $error("%0d predicted result words never arrived", decoded_q.size());
            fails++;
        end
        if (fails == 0) begin
            $display("PASS bmp_stream_decoder");
        end else begin
            $display("FAIL bmp_stream_decoder");
        end
        $finish;
    end
endmodule
